### src/pcas_pkg.sv
// ----------------------------------------------------------------------------
// pcas_pkg
// shared types and constants of the pairwise common ancestor select unit
// ----------------------------------------------------------------------------
package pcas_pkg;

  localparam int unsigned MAX_SEEDS = 8;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned SEED_W    = 3;

  localparam logic [DEPTH_W-1:0] UNREACHABLE = '1;

  // slave tdata: id, year, depth_0 .. depth_7
  localparam int unsigned S_YEAR_LSB  = ID_W;
  localparam int unsigned S_DEPTH_LSB = ID_W + YEAR_W;
  localparam int unsigned S_TDATA_W   = S_DEPTH_LSB + MAX_SEEDS * DEPTH_W;

  // master tdata: seed_a, seed_b, id, depth, year, zero pad to whole bytes
  localparam int unsigned M_FIELDS_W = 2 * SEED_W + ID_W + DEPTH_W + YEAR_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_DUMP = 1'b1
  } action_e;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [DEPTH_W-1:0] depth;
    logic [YEAR_W-1:0]  year;
  } slot_t;

endpackage

### src/pcas_lane.sv
// ----------------------------------------------------------------------------
// pcas_lane
// one seed pair slot: pair depth, lexicographic compare and best update
// ----------------------------------------------------------------------------
module pcas_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           add_en_i,
  input  logic [pcas_pkg::DEPTH_W-1:0]   depth_a_i,
  input  logic [pcas_pkg::DEPTH_W-1:0]   depth_b_i,
  input  logic [pcas_pkg::ID_W-1:0]      id_i,
  input  logic [pcas_pkg::YEAR_W-1:0]    year_i,
  output pcas_pkg::slot_t                slot_o
);
  import pcas_pkg::*;

  logic               valid_q, valid_d;
  logic [ID_W-1:0]    id_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [YEAR_W-1:0]  year_q;
  logic [DEPTH_W-1:0] pair_depth;
  logic               better;
  logic               upd;

  assign pair_depth = (depth_a_i > depth_b_i) ? depth_a_i : depth_b_i;

  // strictly smaller (depth, year, id) wins, equal keeps the stored one
  assign better = !valid_q ||
                  ({pair_depth, year_i, id_i} < {depth_q, year_q, id_q});
  assign upd    = add_en_i && (pair_depth != UNREACHABLE) && better;

  assign valid_d = valid_q || upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      id_q    <= id_i;
      depth_q <= pair_depth;
      year_q  <= year_i;
    end
  end

  assign slot_o = '{valid: valid_q, id: id_q, depth: depth_q, year: year_q};

endmodule

### src/pcas_dump.sv
// ----------------------------------------------------------------------------
// pcas_dump
// merging stage: walks the pair slots in order into the output register
// ----------------------------------------------------------------------------
module pcas_dump #(
  parameter int unsigned SEEDS = 8,
  localparam int unsigned NPairs = SEEDS * (SEEDS - 1) / 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              dump_start_i,
  input  pcas_pkg::slot_t [NPairs-1:0]      slots_i,
  output logic                              busy_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [pcas_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import pcas_pkg::*;

  localparam int unsigned IdxW = (NPairs > 1) ? $clog2(NPairs) : 1;

  logic              busy_q, busy_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [SEED_W-1:0] a_q, a_d, b_q, b_d;
  logic              valid_q, valid_d;
  logic              load;
  logic              at_end;
  slot_t             sel;

  logic [SEED_W-1:0]  out_a_q, out_b_q;
  logic               out_found_q, out_last_q;
  logic [ID_W-1:0]    out_id_q;
  logic [DEPTH_W-1:0] out_depth_q;
  logic [YEAR_W-1:0]  out_year_q;

  assign load   = busy_q && (!valid_q || m_axis_tready_i);
  assign at_end = (idx_q == IdxW'(NPairs - 1));
  assign sel    = slots_i[idx_q];

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    a_d    = a_q;
    b_d    = b_q;
    if (dump_start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      a_d    = '0;
      b_d    = SEED_W'(1);
    end else if (load) begin
      if (at_end) begin
        busy_d = 1'b0;
      end
      idx_d = idx_q + IdxW'(1);
      if (b_q == SEED_W'(SEEDS - 1)) begin
        a_d = a_q + SEED_W'(1);
        b_d = a_q + SEED_W'(2);
      end else begin
        b_d = b_q + SEED_W'(1);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      a_q     <= a_d;
      b_q     <= b_d;
      valid_q <= valid_d;
    end
  end

  // empty slots report zeros
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_a_q     <= a_q;
      out_b_q     <= b_q;
      out_found_q <= sel.valid;
      out_id_q    <= sel.valid ? sel.id    : '0;
      out_depth_q <= sel.valid ? sel.depth : '0;
      out_year_q  <= sel.valid ? sel.year  : '0;
      out_last_q  <= at_end;
    end
  end

  assign busy_o          = busy_q;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{M_PAD_W{1'b0}}, out_year_q, out_depth_q, out_id_q,
                            out_b_q, out_a_q};
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### src/pairwise_common_ancestor_select_unit.sv
// ----------------------------------------------------------------------------
// pairwise_common_ancestor_select_unit
// keeps the best common ancestor for every seed pair and dumps the table
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | tuser: action (add / dump), tdata: id, year, depth_0..7
//  m_axis   | out | tuser: found, tlast: last pair, tdata: seed_a, seed_b,
//           |     |   ancestor_id, ancestor_depth, ancestor_year
//
//  an add beat is taken every cycle when idle; all pair lanes compare and
//  update in the edge that accepts it, so the next beat may follow immediately
//  a dump beat emits SEEDS*(SEEDS-1)/2 beats, one per cycle when m_axis is
//  ready; s_axis is held off until the last slot is in the output register
//  reset clears every slot valid bit at once, no clearing pass is needed
//  a stall on m_axis holds the output register and pauses the slot walk
// ----------------------------------------------------------------------------
module pairwise_common_ancestor_select_unit #(
  parameter int unsigned SEEDS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // id [31:0], year [47:32], depth_0 [63:48] .. depth_7 [175:160]
  input  logic [pcas_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // action
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // seed_a [2:0], seed_b [5:3], ancestor_id [37:6], ancestor_depth [53:38],
  // ancestor_year [69:54], zero [71:70]
  output logic [pcas_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // found
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i
);
  import pcas_pkg::*;

  localparam int unsigned NPairs = SEEDS * (SEEDS - 1) / 2;

  logic                      busy;
  logic                      s_beat;
  logic                      add_en;
  logic                      dump_start;
  logic [ID_W-1:0]           vertex_id;
  logic [YEAR_W-1:0]         vertex_year;
  logic [DEPTH_W-1:0]        depth [MAX_SEEDS];
  slot_t [NPairs-1:0]        slots;

  // only one dump walks the table at a time, adds wait behind it
  assign s_axis_tready_o = !busy;
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;
  assign add_en          = s_beat && (action_e'(s_axis_tuser_i) == ACT_ADD);
  assign dump_start      = s_beat && (action_e'(s_axis_tuser_i) == ACT_DUMP);

  // unpack the beat
  assign vertex_id   = s_axis_tdata_i[ID_W-1:0];
  assign vertex_year = s_axis_tdata_i[S_YEAR_LSB +: YEAR_W];

  for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_depth
    assign depth[i] = s_axis_tdata_i[S_DEPTH_LSB + i * DEPTH_W +: DEPTH_W];
  end

  // one lane per seed pair, slot k in dump order (0,1), (0,2), .. (SEEDS-2,SEEDS-1)
  for (genvar a = 0; a < SEEDS - 1; a++) begin : g_row
    for (genvar b = a + 1; b < SEEDS; b++) begin : g_col
      localparam int unsigned K = a * (2 * SEEDS - a - 1) / 2 + (b - a - 1);
      pcas_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .add_en_i  (add_en),
        .depth_a_i (depth[a]),
        .depth_b_i (depth[b]),
        .id_i      (vertex_id),
        .year_i    (vertex_year),
        .slot_o    (slots[K])
      );
    end
  end

  // merge: walk the slots into the output register
  pcas_dump #(
    .SEEDS (SEEDS)
  ) u_dump (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dump_start_i    (dump_start),
    .slots_i         (slots),
    .busy_o          (busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // a dump beat locks out the input side on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_start |=> !s_axis_tready_o)
    else $error("input taken right after a dump beat");

  // the last beat of a dump always reports the final pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (m_axis_tdata_o[SEED_W-1:0] == SEED_W'(SEEDS - 2)) &&
      (m_axis_tdata_o[2*SEED_W-1:SEED_W] == SEED_W'(SEEDS - 1)))
    else $error("last beat carries a wrong seed pair");

  // pairs are reported with the lower seed first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[SEED_W-1:0] < m_axis_tdata_o[2*SEED_W-1:SEED_W]))
    else $error("seed pair out of order");

  // an empty slot reports zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[M_TDATA_W-1:2*SEED_W] == '0))
    else $error("empty slot with nonzero payload");

endmodule

### tb/sv/pairwise_common_ancestor_select_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pairwise_common_ancestor_select_unit_tb
// streams add and dump beats into the ancestor select unit, tracks its own
// copy of the pair table and checks every dumped pair entry field by field
// ----------------------------------------------------------------------------
module pairwise_common_ancestor_select_unit_tb;
  import pcas_pkg::*;

  localparam int unsigned SEEDS         = 8;
  localparam int unsigned PAIRS         = SEEDS * (SEEDS - 1) / 2;
  localparam int unsigned OUT_B_LSB     = SEED_W;
  localparam int unsigned OUT_ID_LSB    = 2 * SEED_W;
  localparam int unsigned OUT_DEPTH_LSB = OUT_ID_LSB + ID_W;
  localparam int unsigned OUT_YEAR_LSB  = OUT_DEPTH_LSB + DEPTH_W;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 58;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned REPORT_MAX    = 10;

  localparam logic [MAX_SEEDS*DEPTH_W-1:0] ALL_FAR = {MAX_SEEDS{UNREACHABLE}};
  localparam logic [MAX_SEEDS*DEPTH_W-1:0] DEEPEST = {MAX_SEEDS{16'hFFFE}};

  typedef struct packed {
    logic [ID_W-1:0]                     id;
    logic [YEAR_W-1:0]                   year;
    logic [MAX_SEEDS-1:0][DEPTH_W-1:0]   depth;
  } vertex_t;

  typedef struct packed {
    logic [SEED_W-1:0]  seed_a;
    logic [SEED_W-1:0]  seed_b;
    logic               found;
    logic [ID_W-1:0]    id;
    logic [DEPTH_W-1:0] depth;
    logic [YEAR_W-1:0]  year;
    logic               last;
  } pair_report_t;

  // directed row; a dump row may carry one slot value expected for every pair
  typedef struct {
    action_e act;
    vertex_t v;
    bit      typed;
    slot_t   typed_slot;
  } dir_row_t;

  typedef enum {GEN_CLEAN, GEN_NOISY, GEN_BROKEN} gen_style_e;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = ACT_ADD;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;

  // both sides stop idling while this is set
  logic                   steady          = 1'b0;

  slot_t                  best_slot [PAIRS];
  pair_report_t           expected_pairs [$];
  dir_row_t               dir_rows [$];
  int unsigned            mismatch_count  = 0;
  int unsigned            quiet_cycles    = 0;
  pair_report_t           want_pair;
  string                  tag;

  pairwise_common_ancestor_select_unit #(
    .SEEDS(SEEDS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // pair table predictor
  // ---------------------------------------------------------------------------

  // strict lexicographic (depth, year, id) compare, equal triple never wins
  function automatic bit beats_slot(logic [DEPTH_W-1:0] d, logic [YEAR_W-1:0] y,
                                    logic [ID_W-1:0] i, slot_t s);
    if (d != s.depth) return d < s.depth;
    if (y != s.year) return y < s.year;
    return i < s.id;
  endfunction

  // every reachable pair keeps the shallowest, then oldest, then lowest id
  task automatic absorb_vertex(vertex_t v);
    int unsigned k;
    logic [DEPTH_W-1:0] d;
    k = 0;
    for (int unsigned a = 0; a < SEEDS; a++) begin
      for (int unsigned b = a + 1; b < SEEDS; b++) begin
        d = (v.depth[a] > v.depth[b]) ? v.depth[a] : v.depth[b];
        if (d != UNREACHABLE &&
            (!best_slot[k].valid || beats_slot(d, v.year, v.id, best_slot[k]))) begin
          best_slot[k] = '{valid: 1'b1, id: v.id, depth: d, year: v.year};
        end
        k++;
      end
    end
  endtask

  // one beat per pair in (0,1), (0,2) .. (SEEDS-2,SEEDS-1) order
  task automatic queue_dump(bit typed, slot_t typed_slot);
    int unsigned k;
    slot_t s;
    pair_report_t r;
    k = 0;
    for (int unsigned a = 0; a < SEEDS; a++) begin
      for (int unsigned b = a + 1; b < SEEDS; b++) begin
        s        = typed ? typed_slot : best_slot[k];
        r.seed_a = SEED_W'(a);
        r.seed_b = SEED_W'(b);
        r.found  = s.valid;
        r.id     = s.valid ? s.id : '0;
        r.depth  = s.valid ? s.depth : '0;
        r.year   = s.valid ? s.year : '0;
        r.last   = (k == PAIRS - 1);
        expected_pairs.push_back(r);
        k++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t mk_row(action_e act, logic [ID_W-1:0] id,
                                      logic [YEAR_W-1:0] year,
                                      logic [MAX_SEEDS*DEPTH_W-1:0] depths,
                                      bit typed, slot_t typed_slot);
    dir_row_t r;
    r.act        = act;
    r.v.id       = id;
    r.v.year     = year;
    r.v.depth    = depths;
    r.typed      = typed;
    r.typed_slot = typed_slot;
    return r;
  endfunction

  // clean vertices share a narrow depth window per phase and few ids and
  // years, so ties and equal triples show up often; the window sinks phase
  // by phase so later vertices keep displacing stored ones
  function automatic vertex_t make_vertex(int unsigned phase, gen_style_e style);
    vertex_t v;
    int unsigned lone;
    v.id   = (style == GEN_CLEAN) ? ID_W'($urandom_range(15)) : $urandom;
    v.year = (style == GEN_CLEAN) ? YEAR_W'($urandom_range(3)) : YEAR_W'($urandom);
    // broken vertex: at most one seed reachable, so no pair qualifies
    lone   = $urandom_range(SEEDS);
    for (int unsigned s = 0; s < MAX_SEEDS; s++) begin
      if (style == GEN_BROKEN) begin
        v.depth[s] = (s == lone) ? DEPTH_W'($urandom) : UNREACHABLE;
      end else if ($urandom_range(3) == 0) begin
        v.depth[s] = UNREACHABLE;
      end else begin
        v.depth[s] = DEPTH_W'(56000 - phase * 7000 + $urandom_range(7));
      end
    end
    return v;
  endfunction

  // present one beat after random idle cycles and return at the edge that takes
  // it; tvalid stays high for a following beat
  task automatic drive_item(action_e act, vertex_t v);
    while (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {v.depth, v.year, v.id};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic flag_mismatch(string what, logic [M_TDATA_W-1:0] want,
                               logic [M_TDATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back pressure and field checks
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_pairs.size() == 0) begin
        flag_mismatch("beat with no entry pending", '0, m_axis_tdata_o);
      end else begin
        want_pair = expected_pairs.pop_front();
        tag = $sformatf("pair %0d-%0d", want_pair.seed_a, want_pair.seed_b);
        if (m_axis_tdata_o[OUT_B_LSB-1:0] !== want_pair.seed_a) begin
          flag_mismatch({tag, " seed_a"}, M_TDATA_W'(want_pair.seed_a),
                        M_TDATA_W'(m_axis_tdata_o[OUT_B_LSB-1:0]));
        end
        if (m_axis_tdata_o[OUT_B_LSB +: SEED_W] !== want_pair.seed_b) begin
          flag_mismatch({tag, " seed_b"}, M_TDATA_W'(want_pair.seed_b),
                        M_TDATA_W'(m_axis_tdata_o[OUT_B_LSB +: SEED_W]));
        end
        if (m_axis_tdata_o[OUT_ID_LSB +: ID_W] !== want_pair.id) begin
          flag_mismatch({tag, " ancestor_id"}, M_TDATA_W'(want_pair.id),
                        M_TDATA_W'(m_axis_tdata_o[OUT_ID_LSB +: ID_W]));
        end
        if (m_axis_tdata_o[OUT_DEPTH_LSB +: DEPTH_W] !== want_pair.depth) begin
          flag_mismatch({tag, " ancestor_depth"}, M_TDATA_W'(want_pair.depth),
                        M_TDATA_W'(m_axis_tdata_o[OUT_DEPTH_LSB +: DEPTH_W]));
        end
        if (m_axis_tdata_o[OUT_YEAR_LSB +: YEAR_W] !== want_pair.year) begin
          flag_mismatch({tag, " ancestor_year"}, M_TDATA_W'(want_pair.year),
                        M_TDATA_W'(m_axis_tdata_o[OUT_YEAR_LSB +: YEAR_W]));
        end
        // the byte fill above the fields must read as zero
        if (m_axis_tdata_o[M_TDATA_W-1:M_FIELDS_W] !== '0) begin
          flag_mismatch({tag, " pad"}, '0,
                        M_TDATA_W'(m_axis_tdata_o[M_TDATA_W-1:M_FIELDS_W]));
        end
        if (m_axis_tuser_o !== want_pair.found) begin
          flag_mismatch({tag, " found"}, M_TDATA_W'(want_pair.found),
                        M_TDATA_W'(m_axis_tuser_o));
        end
        if (m_axis_tlast_o !== want_pair.last) begin
          flag_mismatch({tag, " last"}, M_TDATA_W'(want_pair.last),
                        M_TDATA_W'(m_axis_tlast_o));
        end
      end
    end
  end

  // watchdog: too long without a beat on either side ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pairwise_common_ancestor_select_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    action_e act;
    vertex_t v;
    int unsigned pick;

    foreach (best_slot[k]) best_slot[k] = '0;

    // table empty after reset, and still empty after a vertex that reaches no seed
    dir_rows.push_back(mk_row(ACT_DUMP, '0, '0, ALL_FAR, 1'b1, '0));
    dir_rows.push_back(mk_row(ACT_ADD, 32'h1, '0, ALL_FAR, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_DUMP, '0, '0, ALL_FAR, 1'b1, '0));
    // deepest reachable depth, largest id and year fill every slot
    dir_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, DEEPEST, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_DUMP, '0, '0, ALL_FAR, 1'b1,
                              slot_t'{1'b1, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF}));
    // equal triple keeps the stored one, then id and year tiebreaks
    dir_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, DEEPEST, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, 32'h0, 16'hFFFF, DEEPEST, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 16'h0, DEEPEST, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_DUMP, '0, '0, ALL_FAR, 1'b0, '0));
    // a single reachable seed at depth zero forms no pair
    dir_rows.push_back(mk_row(ACT_ADD, 32'h5, 16'hFFFF, {{7{UNREACHABLE}}, 16'd0}, 1'b0, '0));
    // pair depth is the larger of the two seed depths
    dir_rows.push_back(mk_row(ACT_ADD, 32'hA5A5_A5A5, 16'h5A5A,
                              {{6{UNREACHABLE}}, 16'd20000, 16'd60000}, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, 32'h5A5A_5A5A, 16'hA5A5,
                              {16'd0, 16'hFFFE, 16'd40000, 16'd50000,
                               16'd58000, 16'd57000, 16'd60000, UNREACHABLE}, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_DUMP, '0, '0, ALL_FAR, 1'b0, '0));
    // dump ignores whatever its data carries
    dir_rows.push_back(mk_row(ACT_DUMP, 32'h1357_9BDF, 16'h2468,
                              {MAX_SEEDS{16'h0001}}, 1'b0, '0));
    dir_rows.push_back(mk_row(ACT_ADD, 32'h0, 16'h0, DEEPEST, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].act, dir_rows[i].v);
      if (dir_rows[i].act == ACT_ADD) begin
        absorb_vertex(dir_rows[i].v);
      end else begin
        queue_dump(dir_rows[i].typed, dir_rows[i].typed_slot);
      end
    end

    // random part: mostly clean vertices, some noisy ids and years, some vertices
    // with no pair at all, random dumps within a phase and a dump closing every phase
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p == 4) begin
        steady <= 1'b1;
      end else if (p == 5) begin
        steady <= 1'b0;
      end
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        act  = (n == PHASE_ITEMS - 1 || pick < 8) ? ACT_DUMP : ACT_ADD;
        v    = make_vertex(p, (pick < 16) ? GEN_BROKEN : ((pick < 26) ? GEN_NOISY : GEN_CLEAN));
        drive_item(act, v);
        if (act == ACT_ADD) begin
          absorb_vertex(v);
        end else begin
          queue_dump(1'b0, '0);
        end
      end
      if (p == 2) begin
        // hold the input off until the whole dump has drained
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (expected_pairs.size() != 0);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pairs.size() != 0);
    // catch stray beats after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    mismatch_count += expected_pairs.size();
    if (mismatch_count == 0) begin
      $display("pairwise_common_ancestor_select_unit verification clean");
    end else begin
      $display("pairwise_common_ancestor_select_unit verification failed");
    end
    $finish;
  end

endmodule
